@@ rtl/pabg_pkg.sv @@
package pabg_pkg;

	localparam int LINES     = 8;
	localparam int TIME_BITS = 32;
	localparam int IDX_W     = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int CNT_W     = 16;
	localparam int MAG_W     = 12;
	localparam int MUL_W     = IDX_W + MAG_W;
	localparam int OUT_LINES = 8;

	localparam logic [31:0] RESET_REPEAT_INTERVAL = 32'd400000;
	localparam logic [15:0] RESET_BURST_TOGGLES   = 16'd10;
	localparam logic [15:0] RESET_HALF_PERIOD     = 16'd42;
	localparam logic [11:0] RESET_PHASE_OFFSET    = 12'd1;

	typedef enum logic [1:0] {
		REG_REPEAT_INTERVAL = 2'd0,
		REG_BURST_TOGGLES   = 2'd1,
		REG_HALF_PERIOD     = 2'd2,
		REG_PHASE_OFFSET    = 2'd3
	} reg_index_t;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic advance;
		logic start;
		logic running;
		logic finish;
		logic reversed;
	} cell_ctl_t;

endpackage

@@ rtl/pabg_cell.sv @@
module pabg_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pabg_pkg::cell_ctl_t         ctl,
	input  logic [pabg_pkg::IDX_W-1:0]  idx,
	input  pabg_pkg::time_t             time_next,
	input  logic [pabg_pkg::MAG_W-1:0]  mag,
	input  logic [pabg_pkg::CNT_W-1:0]  burst_toggles,
	input  logic [15:0]                 half_period,
	input  logic                        done_in,
	output logic                        done_out,
	output logic                        level
);
	import pabg_pkg::*;

	time_t              last_q;
	logic [CNT_W-1:0]   count_q;
	logic               level_q;
	logic [IDX_W-1:0]   mult;
	logic [MUL_W-1:0]   offset;
	time_t              elapsed;
	logic               toggle;
	logic [CNT_W-1:0]   count_new;

	assign mult   = ctl.reversed ? IDX_W'(LINES - 1) - idx : idx;
	assign offset = MUL_W'(mult) * MUL_W'(mag);
	assign elapsed = time_next - last_q;

	// The elapsed time is read as signed, so a start still in the future never toggles.
	assign toggle = ctl.running && (count_q < burst_toggles) && !elapsed[TIME_BITS-1]
		&& (elapsed > time_t'(half_period));

	assign count_new = ctl.start ? '0 : count_q + CNT_W'(toggle);
	assign done_out  = done_in && (count_new >= burst_toggles);
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			count_q <= '0;
			level_q <= 1'b0;
		end else if (ctl.advance) begin
			if (ctl.start) begin
				last_q  <= time_next + time_t'(offset);
				level_q <= 1'b0;
			end else if (toggle) begin
				last_q  <= time_next;
				level_q <= ~level_q;
			end
			if (ctl.finish) begin
				count_q <= '0;
			end else begin
				count_q <= count_new;
			end
		end
	end

endmodule

@@ rtl/phased_array_burst_generator_core.sv @@
// Burst generator for a phased transmit array. Every input transfer carries one
// bit, tick; each accepted transfer with tick set advances the internal time by
// one, and every accepted transfer, with or without a tick, returns one output
// transfer with the eight line levels and the burst flag as they stand after it.
// A burst starts once more than repeat_interval ticks have passed since the last
// one ended; line k then waits k times the phase offset (mirrored for a negative
// offset) and toggles whenever more than half_period ticks have passed, until each
// line has made burst_toggles toggles. A row of identical line cells evaluates all
// lines in the cycle of the transfer, so the block takes one transfer per clock;
// the result sits in an output register, and a new transfer is taken whenever
// that register is empty or being emptied. Configuration must be written only
// while no output is pending; the block itself does not enforce this.
module phased_array_burst_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] tx_lines, [8] burst_active, [15:9] zero
);
	import pabg_pkg::*;

	logic [31:0]       repeat_interval_q;
	logic [CNT_W-1:0]  burst_toggles_q;
	logic [15:0]       half_period_q;
	logic [MAG_W-1:0]  phase_offset_q;

	time_t             time_q;
	time_t             end_time_q;
	logic              in_burst_q;
	logic              out_valid_q;
	logic [15:0]       out_data_q;

	logic              accept;
	time_t             time_next;
	logic              start;
	logic              finish;
	logic [MAG_W-1:0]  mag;
	cell_ctl_t         ctl;
	logic [LINES:0]    done_chain;
	logic [LINES-1:0]  levels;
	logic [OUT_LINES-1:0] tx_lines;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign time_next = time_q + time_t'(1);
	assign start     = !in_burst_q && ((time_next - end_time_q) > time_t'(repeat_interval_q));
	assign mag       = phase_offset_q[MAG_W-1] ? MAG_W'(-phase_offset_q) : phase_offset_q;
	assign finish    = (in_burst_q || start) && done_chain[LINES];

	always_comb begin
		ctl.advance  = accept && s_tdata[0];
		ctl.start    = start;
		ctl.running  = in_burst_q;
		ctl.finish   = finish;
		ctl.reversed = phase_offset_q[MAG_W-1];
	end

	assign done_chain[0] = 1'b1;

	for (genvar k = 0; k < LINES; k++) begin : g_line
		pabg_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl),
			.idx           (IDX_W'(k)),
			.time_next     (time_next),
			.mag           (mag),
			.burst_toggles (burst_toggles_q),
			.half_period   (half_period_q),
			.done_in       (done_chain[k]),
			.done_out      (done_chain[k+1]),
			.level         (levels[k])
		);
	end

	// Line levels after this transfer: cleared on a burst start, else flipped on a toggle.
	always_comb begin
		tx_lines = '0;
		for (int b = 0; b < OUT_LINES; b++) begin
			if (b < LINES) begin
				tx_lines[b] = levels[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_interval_q <= RESET_REPEAT_INTERVAL;
			burst_toggles_q   <= RESET_BURST_TOGGLES;
			half_period_q     <= RESET_HALF_PERIOD;
			phase_offset_q    <= RESET_PHASE_OFFSET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				REG_BURST_TOGGLES:   burst_toggles_q   <= cfg_data[CNT_W-1:0];
				REG_HALF_PERIOD:     half_period_q     <= cfg_data[15:0];
				REG_PHASE_OFFSET:    phase_offset_q    <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			end_time_q <= '0;
			in_burst_q <= 1'b0;
		end else if (ctl.advance) begin
			time_q <= time_next;
			if (finish) begin
				end_time_q <= time_next;
				in_burst_q <= 1'b0;
			end else if (start) begin
				in_burst_q <= 1'b1;
			end
		end
	end

	// The cells update on the edge that accepts the transfer, so the output is built
	// from their register values in the cycle after; m_tdata shows those values while
	// pending_q is set, and out_data_q then holds them until the transfer is taken.
	logic pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_q   <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			pending_q <= accept;
		end
	end

	logic [15:0] live_data;
	assign live_data = {7'd0, in_burst_q, tx_lines};

	always_ff @(posedge clk) begin
		if (pending_q) begin
			out_data_q <= live_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pending_q ? live_data : out_data_q;

endmodule
